@@ design/affine_texture_walker_top_assert.svh @@
// Assertion macros used by the checker in atw_checker.sv.
`ifndef AFFINE_TEXTURE_WALKER_TOP_ASSERT_SVH
`define AFFINE_TEXTURE_WALKER_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define ATW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define ATW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked while in reset.
`define ATW_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/atw_pkg.sv @@
`default_nettype none

package atw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 23;

  localparam int COORD_W   = 24;
  localparam int COL_CNT_W = 7;
  localparam int ROW_CNT_W = 5;
  localparam int TEX_IDX_W = 8;
  localparam int GLYPH_W   = 8;
  localparam int TEX_DEPTH = 256;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_PIXEL   = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam int REG_NUM   = 6;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_A_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_C_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_C_Y = 3'd5;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Step divider: |diff| < 2^24, quotient estimate from a reciprocal, one correction.
  localparam int DIFF_W   = COORD_W + 1;
  localparam int RECIP_SH = 25;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int DIV_W    = 7;
  localparam int PROD_W   = DIFF_W + RECIP_W;
  localparam int REM_W    = DIFF_W + DIV_W;
  localparam int LANES    = 4;
  localparam int STEP_LAT = 4;
  localparam int SETTLE_W = 3;

  localparam logic [DIV_W-1:0] LANE_DIV [LANES] = '{
    DIV_W'(COLS), DIV_W'(COLS), DIV_W'(ROWS), DIV_W'(ROWS)
  };
  localparam logic [RECIP_W-1:0] LANE_RECIP [LANES] = '{
    RECIP_W'((1 << RECIP_SH) / COLS), RECIP_W'((1 << RECIP_SH) / COLS),
    RECIP_W'((1 << RECIP_SH) / ROWS), RECIP_W'((1 << RECIP_SH) / ROWS)
  };

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;
  localparam logic [GLYPH_W-1:0] GLYPH_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_PIXEL,
    OP_RESTART
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [TEX_IDX_W-1:0] index;
    logic [GLYPH_W-1:0]   value;
  } q_entry_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] col_x;
    logic [COORD_W-1:0] col_y;
    logic [COORD_W-1:0] row_x;
    logic [COORD_W-1:0] row_y;
    logic [COORD_W-1:0] a_x;
    logic [COORD_W-1:0] a_y;
  } steps_t;

  // Power-up checkerboard: space where the quadrant row and column agree.
  function automatic logic [GLYPH_W-1:0] default_texel(input logic [TEX_IDX_W-1:0] idx);
    return (idx[7] == idx[3]) ? GLYPH_SPACE : GLYPH_PLUS;
  endfunction

endpackage

`default_nettype wire

@@ design/affine_texture_walker_top.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata = texel_index, texel_value; tuser = mode
// m_axis    out        tdata = glyph; tuser = row_end; tlast = frame_end
// cfg       in         cfg_index_i = corner register, cfg_data_i = signed 10.14 value
//
// Sustained rate is one word per cycle unless output or step unit stalls;
// pixels pass through the four-entry queue into the output register once the
// output slot is free. The step divider pipeline settles after reset or a
// config write; restarts, explicit or at frame end, wait for it. Reset clears
// queue, walker and texel valid bits at once. A stalled output only blocks pixels.
`default_nettype none

module affine_texture_walker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // texel_index [7:0], texel_value [15:8]
  input  wire logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // glyph [7:0]
  output logic             m_axis_tuser,   // row_end [0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  atw_pkg::q_entry_t head;
  logic              head_vld;
  logic              pop;
  atw_pkg::steps_t   steps;

  assign cfg_ready_o = 1'b1;

  atw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_o        (head),
    .head_vld_o    (head_vld),
    .pop_i         (pop)
  );

  atw_step_unit u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .steps_o     (steps)
  );

  atw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_vld_i    (head_vld),
    .pop_o         (pop),
    .steps_i       (steps),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ design/atw_front.sv @@
`default_nettype none

module atw_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // texel_index, texel_value
  input  wire logic [1:0]                   s_axis_tuser,  // mode
  output atw_pkg::q_entry_t                 head_o,
  output logic                              head_vld_o,
  input  wire logic                         pop_i
);

  atw_pkg::q_entry_t                  entry_q [atw_pkg::Q_DEPTH];
  logic [atw_pkg::Q_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [atw_pkg::Q_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [atw_pkg::Q_CNT_W-1:0]        cnt_q, cnt_d;
  atw_pkg::q_entry_t                  in_entry;
  logic                               in_known;
  logic                               push;
  logic                               pop;

  always_comb begin
    in_entry.index = s_axis_tdata[7:0];
    in_entry.value = s_axis_tdata[15:8];
    in_entry.op    = atw_pkg::OP_WRITE;
    in_known       = 1'b1;
    case (s_axis_tuser)
      atw_pkg::MODE_WRITE:   in_entry.op = atw_pkg::OP_WRITE;
      atw_pkg::MODE_PIXEL:   in_entry.op = atw_pkg::OP_PIXEL;
      atw_pkg::MODE_RESTART: in_entry.op = atw_pkg::OP_RESTART;
      default:               in_known    = 1'b0;  // drop unused mode
    endcase
  end

  assign s_axis_tready = (cnt_q != atw_pkg::Q_CNT_W'(atw_pkg::Q_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready && in_known;
  assign head_vld_o    = (cnt_q != '0);
  assign pop           = pop_i && head_vld_o;
  assign head_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_entry;
    end
  end

endmodule

`default_nettype wire

@@ design/atw_step_unit.sv @@
`default_nettype none

module atw_step_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [atw_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [atw_pkg::COORD_W-1:0]       cfg_data_i,
  output atw_pkg::steps_t                        steps_o
);

  logic [atw_pkg::COORD_W-1:0]  corner_q [atw_pkg::REG_NUM];
  logic [atw_pkg::COORD_W-1:0]  lane_to   [atw_pkg::LANES];
  logic [atw_pkg::COORD_W-1:0]  lane_from [atw_pkg::LANES];
  logic [atw_pkg::DIFF_W-1:0]   diff      [atw_pkg::LANES];

  logic [atw_pkg::DIFF_W-1:0]   mag1_q  [atw_pkg::LANES];
  logic                         neg1_q  [atw_pkg::LANES];
  logic [atw_pkg::PROD_W-1:0]   prod2_q [atw_pkg::LANES];
  logic [atw_pkg::DIFF_W-1:0]   mag2_q  [atw_pkg::LANES];
  logic                         neg2_q  [atw_pkg::LANES];
  logic [atw_pkg::DIFF_W-1:0]   quo3_d  [atw_pkg::LANES];
  logic [atw_pkg::DIFF_W-1:0]   quo3_q  [atw_pkg::LANES];
  logic                         neg3_q  [atw_pkg::LANES];
  logic [atw_pkg::REM_W-1:0]    rem3    [atw_pkg::LANES];
  logic [atw_pkg::DIFF_W-1:0]   sgn4_d  [atw_pkg::LANES];
  logic [atw_pkg::COORD_W-1:0]  step_q  [atw_pkg::LANES];

  logic [atw_pkg::SETTLE_W-1:0] settle_q, settle_d;
  logic                         wr_en;

  assign wr_en = cfg_valid_i && (cfg_index_i < atw_pkg::REG_IDX_W'(atw_pkg::REG_NUM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < atw_pkg::REG_NUM; r++) begin
        corner_q[r] <= '0;
      end
    end else if (wr_en) begin
      corner_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Count down the pipeline fill after reset or any write.
  always_comb begin
    settle_d = settle_q;
    if (cfg_valid_i) begin
      settle_d = atw_pkg::SETTLE_W'(atw_pkg::STEP_LAT);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= atw_pkg::SETTLE_W'(atw_pkg::STEP_LAT);
    end else begin
      settle_q <= settle_d;
    end
  end

  always_comb begin
    lane_to[0]   = corner_q[atw_pkg::REG_B_X];
    lane_from[0] = corner_q[atw_pkg::REG_A_X];
    lane_to[1]   = corner_q[atw_pkg::REG_B_Y];
    lane_from[1] = corner_q[atw_pkg::REG_A_Y];
    lane_to[2]   = corner_q[atw_pkg::REG_C_X];
    lane_from[2] = corner_q[atw_pkg::REG_A_X];
    lane_to[3]   = corner_q[atw_pkg::REG_C_Y];
    lane_from[3] = corner_q[atw_pkg::REG_A_Y];
    for (int l = 0; l < atw_pkg::LANES; l++) begin
      diff[l] = {lane_to[l][atw_pkg::COORD_W-1], lane_to[l]}
              - {lane_from[l][atw_pkg::COORD_W-1], lane_from[l]};
    end
  end

  // The estimate is low by at most one; add it back when the remainder allows.
  always_comb begin
    for (int l = 0; l < atw_pkg::LANES; l++) begin
      quo3_d[l] = prod2_q[l][atw_pkg::PROD_W-2 -: atw_pkg::DIFF_W];
      rem3[l]   = {{atw_pkg::DIV_W{1'b0}}, mag2_q[l]}
                - atw_pkg::REM_W'(quo3_d[l] * atw_pkg::LANE_DIV[l]);
      if (rem3[l] >= {{atw_pkg::DIFF_W{1'b0}}, atw_pkg::LANE_DIV[l]}) begin
        quo3_d[l] = quo3_d[l] + 1'b1;
      end
      sgn4_d[l] = neg3_q[l] ? (~quo3_q[l] + 1'b1) : quo3_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < atw_pkg::LANES; l++) begin
      neg1_q[l]  <= diff[l][atw_pkg::DIFF_W-1];
      mag1_q[l]  <= diff[l][atw_pkg::DIFF_W-1] ? (~diff[l] + 1'b1) : diff[l];
      prod2_q[l] <= atw_pkg::PROD_W'(mag1_q[l] * atw_pkg::LANE_RECIP[l]);
      mag2_q[l]  <= mag1_q[l];
      neg2_q[l]  <= neg1_q[l];
      quo3_q[l]  <= quo3_d[l];
      neg3_q[l]  <= neg2_q[l];
      step_q[l]  <= sgn4_d[l][atw_pkg::COORD_W-1:0];
    end
  end

  assign steps_o.ok    = (settle_q == '0);
  assign steps_o.col_x = step_q[0];
  assign steps_o.col_y = step_q[1];
  assign steps_o.row_x = step_q[2];
  assign steps_o.row_y = step_q[3];
  assign steps_o.a_x   = corner_q[atw_pkg::REG_A_X];
  assign steps_o.a_y   = corner_q[atw_pkg::REG_A_Y];

endmodule

`default_nettype wire

@@ design/atw_back.sv @@
`default_nettype none

module atw_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire atw_pkg::q_entry_t    head_i,
  input  wire logic                 head_vld_i,
  output logic                      pop_o,
  input  wire atw_pkg::steps_t      steps_i,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // glyph
  output logic                      m_axis_tuser,  // row_end
  output logic                      m_axis_tlast   // frame_end
);

  logic [atw_pkg::GLYPH_W-1:0]   tex_mem [atw_pkg::TEX_DEPTH];
  logic [atw_pkg::TEX_DEPTH-1:0] tex_vld_q;

  logic [atw_pkg::COORD_W-1:0]   org_x_q, org_x_d, org_y_q, org_y_d;
  logic [atw_pkg::COORD_W-1:0]   pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [atw_pkg::COORD_W-1:0]   col_x_q, col_x_d, col_y_q, col_y_d;
  logic [atw_pkg::COORD_W-1:0]   row_x_q, row_x_d, row_y_q, row_y_d;
  logic [atw_pkg::COL_CNT_W-1:0] col_cnt_q, col_cnt_d;
  logic [atw_pkg::ROW_CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic                          out_vld_q, out_vld_d;

  logic [atw_pkg::GLYPH_W-1:0]   rd_data_q;
  logic                          rd_vld_q;
  logic [atw_pkg::TEX_IDX_W-1:0] rd_idx_q;
  logic                          row_end_q;
  logic                          frame_end_q;

  logic [atw_pkg::TEX_IDX_W-1:0] pix_idx;
  logic                          last_col, last_row, fend;
  logic                          slot_free, can_go, do_restart;
  logic                          wr_en, rd_en;

  assign pix_idx   = {pix_x_q[17:14], pix_y_q[17:14]};
  assign last_col  = (col_cnt_q >= atw_pkg::COL_CNT_W'(atw_pkg::COLS - 1));
  assign last_row  = (row_cnt_q >= atw_pkg::ROW_CNT_W'(atw_pkg::ROWS - 1));
  assign fend      = last_col && last_row;
  assign slot_free = !out_vld_q || m_axis_tready;

  // Hold restarts and frame-end pixels until the step unit catches up.
  always_comb begin
    case (head_i.op)
      atw_pkg::OP_WRITE:   can_go = 1'b1;
      atw_pkg::OP_RESTART: can_go = steps_i.ok;
      atw_pkg::OP_PIXEL:   can_go = slot_free && (!fend || steps_i.ok);
      default:             can_go = 1'b0;
    endcase
  end

  assign pop_o = head_vld_i && can_go;
  assign wr_en = pop_o && (head_i.op == atw_pkg::OP_WRITE);
  assign rd_en = pop_o && (head_i.op == atw_pkg::OP_PIXEL);

  always_comb begin
    org_x_d    = org_x_q;
    org_y_d    = org_y_q;
    pix_x_d    = pix_x_q;
    pix_y_d    = pix_y_q;
    col_x_d    = col_x_q;
    col_y_d    = col_y_q;
    row_x_d    = row_x_q;
    row_y_d    = row_y_q;
    col_cnt_d  = col_cnt_q;
    row_cnt_d  = row_cnt_q;
    do_restart = 1'b0;
    if (pop_o && (head_i.op == atw_pkg::OP_RESTART)) begin
      do_restart = 1'b1;
    end else if (rd_en) begin
      if (fend) begin
        do_restart = 1'b1;
      end else if (last_col) begin
        org_x_d   = org_x_q + row_x_q;
        org_y_d   = org_y_q + row_y_q;
        pix_x_d   = org_x_q + row_x_q;
        pix_y_d   = org_y_q + row_y_q;
        col_cnt_d = '0;
        row_cnt_d = row_cnt_q + 1'b1;
      end else begin
        pix_x_d   = pix_x_q + col_x_q;
        pix_y_d   = pix_y_q + col_y_q;
        col_cnt_d = col_cnt_q + 1'b1;
      end
    end
    if (do_restart) begin
      col_x_d   = steps_i.col_x;
      col_y_d   = steps_i.col_y;
      row_x_d   = steps_i.row_x;
      row_y_d   = steps_i.row_y;
      org_x_d   = steps_i.a_x;
      org_y_d   = steps_i.a_y;
      pix_x_d   = steps_i.a_x;
      pix_y_d   = steps_i.a_y;
      col_cnt_d = '0;
      row_cnt_d = '0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (rd_en) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      pix_x_q   <= '0;
      pix_y_q   <= '0;
      col_x_q   <= '0;
      col_y_q   <= '0;
      row_x_q   <= '0;
      row_y_q   <= '0;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      out_vld_q <= 1'b0;
      tex_vld_q <= '0;
    end else begin
      org_x_q   <= org_x_d;
      org_y_q   <= org_y_d;
      pix_x_q   <= pix_x_d;
      pix_y_q   <= pix_y_d;
      col_x_q   <= col_x_d;
      col_y_q   <= col_y_d;
      row_x_q   <= row_x_d;
      row_y_q   <= row_y_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      out_vld_q <= out_vld_d;
      if (wr_en) begin
        tex_vld_q[head_i.index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tex_mem[head_i.index] <= head_i.value;
    end
    if (rd_en) begin
      rd_data_q <= tex_mem[pix_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_vld_q    <= tex_vld_q[pix_idx];
      rd_idx_q    <= pix_idx;
      row_end_q   <= last_col;
      frame_end_q <= fend;
    end
  end

  // Unwritten entries read as the power-up pattern.
  assign m_axis_tdata  = rd_vld_q ? rd_data_q : atw_pkg::default_texel(rd_idx_q);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = row_end_q;
  assign m_axis_tlast  = frame_end_q;

endmodule

`default_nettype wire

@@ design/atw_checker.sv @@
`default_nettype none
`include "affine_texture_walker_top_assert.svh"

module atw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);

  logic       out_stall;
  logic [9:0] out_word;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // Stalled output word holds.
  `ATW_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
  // Frame end is always a row end.
  `ATW_ASSERT_IMP(a_frame_is_row_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
  // Output is idle the cycle after any edge in reset.
  `ATW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni, !m_axis_tvalid)
  // Config writes are never back-pressured.
  `ATW_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind affine_texture_walker_top atw_checker u_atw_checker (.*);

`default_nettype wire

@@ dv/atw_glyph_checker.sv @@
`timescale 1ns / 1ps

module atw_glyph_checker
  import atw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [15:0]          s_data_i,   // texel_index [7:0], texel_value [15:8]
  input  logic [1:0]           s_user_i,   // mode [1:0]
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [7:0]           m_data_i,   // glyph [7:0]
  input  logic                 m_user_i,   // row_end [0]
  input  logic                 m_last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               row_end;
    logic               frame_end;
  } glyph_word_t;

  glyph_word_t glyph_due[$];
  glyph_word_t want;

  logic [COORD_W-1:0]   corner [REG_NUM];
  logic [GLYPH_W-1:0]   texels [TEX_DEPTH];
  logic [COORD_W-1:0]   origin_x, origin_y, spot_x, spot_y;
  logic [COORD_W-1:0]   col_step_x, col_step_y, row_step_x, row_step_y;
  logic [COL_CNT_W-1:0] col_n;
  logic [ROW_CNT_W-1:0] row_n;

  // Exact corner difference over the divisor, truncated toward zero, wrapped to the coordinate width.
  function automatic logic [COORD_W-1:0] fixed_step(input logic [COORD_W-1:0] to,
                                                    input logic [COORD_W-1:0] from,
                                                    input int div);
    longint span;
    span = longint'($signed(to)) - longint'($signed(from));
    return COORD_W'(span / div);
  endfunction

  task automatic start_frame();
    col_step_x = fixed_step(corner[REG_B_X], corner[REG_A_X], COLS);
    col_step_y = fixed_step(corner[REG_B_Y], corner[REG_A_Y], COLS);
    row_step_x = fixed_step(corner[REG_C_X], corner[REG_A_X], ROWS);
    row_step_y = fixed_step(corner[REG_C_Y], corner[REG_A_Y], ROWS);
    origin_x = corner[REG_A_X];
    origin_y = corner[REG_A_Y];
    spot_x = corner[REG_A_X];
    spot_y = corner[REG_A_Y];
    col_n = '0;
    row_n = '0;
  endtask

  task automatic clear_walk();
    int i;
    for (i = 0; i < TEX_DEPTH; i++) begin
      texels[i] = ((i / 16 < 8) == (i % 16 < 8)) ? GLYPH_SPACE : GLYPH_PLUS;
    end
    for (i = 0; i < REG_NUM; i++) begin
      corner[i] = '0;
    end
    origin_x = '0;
    origin_y = '0;
    spot_x = '0;
    spot_y = '0;
    col_step_x = '0;
    col_step_y = '0;
    row_step_x = '0;
    row_step_y = '0;
    col_n = '0;
    row_n = '0;
    glyph_due.delete();
  endtask

  task automatic walk_pixel();
    glyph_word_t w;
    logic last_col, last_row;
    last_col = (col_n >= COLS - 1);
    last_row = (row_n >= ROWS - 1);
    // x nibble selects the texture row, y nibble the column
    w.glyph = texels[{spot_x[17:14], spot_y[17:14]}];
    w.row_end = last_col;
    w.frame_end = last_col && last_row;
    glyph_due.push_back(w);
    if (w.frame_end) begin
      start_frame();
    end else if (last_col) begin
      origin_x = origin_x + row_step_x;
      origin_y = origin_y + row_step_y;
      spot_x = origin_x;
      spot_y = origin_y;
      col_n = '0;
      row_n = row_n + 1'b1;
    end else begin
      spot_x = spot_x + col_step_x;
      spot_y = spot_y + col_step_y;
      col_n = col_n + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_walk();
      fail_count_o = 0;
    end else begin
      // outputs first: a word leaving now came from an earlier input
      if (m_valid_i && m_ready_i) begin
        if (glyph_due.size() == 0) begin
          $error("unexpected glyph word: glyph %0h row_end %0b frame_end %0b",
                 m_data_i, m_user_i, m_last_i);
          fail_count_o++;
        end else begin
          want = glyph_due.pop_front();
          if (m_data_i !== want.glyph) begin
            $error("glyph: expected %0h, got %0h", want.glyph, m_data_i);
            fail_count_o++;
          end
          if (m_user_i !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, m_user_i);
            fail_count_o++;
          end
          if (m_last_i !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, m_last_i);
            fail_count_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        case (s_user_i)
          MODE_WRITE:   texels[s_data_i[7:0]] = s_data_i[15:8];
          MODE_PIXEL:   walk_pixel();
          MODE_RESTART: start_frame();
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < REG_NUM) begin
        corner[cfg_index_i] = cfg_data_i;
      end
    end
    pending_o = glyph_due.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import atw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_go = 1'b0;
  logic holding = 1'b0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;

  always #5 clk = ~clk;

  affine_texture_walker_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  atw_glyph_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_tvalid),
    .s_ready_i    (s_tready),
    .s_data_i     (s_tdata),
    .s_user_i     (s_tuser),
    .m_valid_i    (m_tvalid),
    .m_ready_i    (m_tready),
    .m_data_i     (m_tdata),
    .m_user_i     (m_tuser),
    .m_last_i     (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) begin
    if (holding) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the input queue fills and back-pressures.
  initial begin
    wait (hold_go);
    @(negedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Entered and left just after a falling edge; valid stays high for back-to-back words.
  task automatic send_word(input logic [1:0] mode, input logic [7:0] idx,
                           input logic [7:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_mixed(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_word(MODE_PIXEL, 8'($urandom), 8'($urandom));
      end else if (pick < 92) begin
        send_word(MODE_WRITE, 8'($urandom), 8'($urandom));
      end else if (pick < 96) begin
        send_word(MODE_RESTART, 8'($urandom), 8'($urandom));
      end else begin
        send_word(MODE_UNUSED, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Drop valid, drain expected glyphs, then let writes and restarts still in flight finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_corner(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_corners(input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                             input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
                             input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    settle();
    write_corner(REG_A_X, ax);
    write_corner(REG_A_Y, ay);
    write_corner(REG_B_X, bx);
    write_corner(REG_B_Y, by);
    write_corner(REG_C_X, cx);
    write_corner(REG_C_Y, cy);
    cfg_valid <= 1'b0;
  endtask

  // Corner within 128 texels of the base so the walk sweeps the texture at a sane zoom.
  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] base);
    return base + COORD_W'($urandom_range(0, 24'h3FFFFF)) - 24'h200000;
  endfunction

  initial begin
    int phase;
    logic [COORD_W-1:0] ax, ay;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // pixels straight out of reset walk the zero frame
    send_word(MODE_PIXEL, 8'h00, 8'h00);
    send_word(MODE_PIXEL, 8'hFF, 8'hFF);
    send_word(MODE_UNUSED, 8'hFF, 8'hFF);
    send_word(MODE_WRITE, 8'h00, 8'hFF);
    send_word(MODE_WRITE, 8'hFF, 8'h00);
    send_word(MODE_WRITE, 8'h0F, 8'hA5);
    send_word(MODE_PIXEL, 8'h00, 8'h00);
    send_word(MODE_RESTART, 8'h00, 8'h00);
    send_word(MODE_PIXEL, 8'hFF, 8'hFF);

    set_corners(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_word(MODE_RESTART, 8'hFF, 8'hFF);
    repeat (4) send_word(MODE_PIXEL, 8'($urandom), 8'($urandom));
    send_word(MODE_WRITE, 8'hF0, 8'h3C);
    send_word(MODE_PIXEL, 8'h00, 8'h00);

    set_corners(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_word(MODE_RESTART, 8'h00, 8'h00);
    repeat (4) send_word(MODE_PIXEL, 8'($urandom), 8'($urandom));
    send_word(MODE_UNUSED, 8'h00, 8'h00);
    send_word(MODE_PIXEL, 8'hFF, 8'hFF);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 45;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 45;
        end
        default: begin
          idle_pct = 14;
          stall_pct = 14;
        end
      endcase
      ax = COORD_W'($urandom);
      ay = COORD_W'($urandom);
      if (phase == 1) begin
        set_corners(ax, ay, COORD_W'($urandom), COORD_W'($urandom),
                    COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        set_corners(ax, ay, nudge(ax), nudge(ay), nudge(ax), nudge(ay));
      end
      send_word(MODE_RESTART, 8'($urandom), 8'($urandom));
      if (phase == 0) begin
        hold_go = 1'b1;
        repeat (40) send_word(MODE_PIXEL, 8'($urandom), 8'($urandom));
      end
      send_mixed(200);
    end

    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
